// ===== rtl/tw_dmi_pkg.sv =====
// package for the two-wire debug bus dmi master
// holds payload structs, operation codes and frame constants
// no dependencies
package tw_dmi_pkg;

  // operation codes, also the command codes of an input transaction
  localparam logic [1:0] OP_IDLE   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_LRESET = 2'd3;

  // last bit slot of a read or write frame
  localparam logic [7:0] LAST_SLOT_RW = 8'd54;

  // default number of clock pulses in a line reset
  localparam int RESET_PULSES_DEFAULT = 100;

  // half period after reset, in ticks
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  address;
    logic [31:0] write_data;
    logic        data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_level;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [31:0] read_data;
    logic [3:0]  reply_status;
    logic [1:0]  reply_parity;
  } out_item_t;

endpackage

// ===== rtl/tw_dmi_frame.sv =====
// frame sequencer: wire state registers and one-tick next-state logic
// depends on tw_dmi_pkg
module tw_dmi_frame #(
  parameter int RESET_PULSES = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  tw_dmi_pkg::in_item_t item_i,
  input  logic [7:0]           half_period_i,
  output tw_dmi_pkg::out_item_t res_o
);
  import tw_dmi_pkg::*;

  localparam logic [1:0] RECV_NONE = 2'd0;
  localparam logic [1:0] RECV_DATA = 2'd1;
  localparam logic [1:0] RECV_STAT = 2'd2;
  localparam logic [7:0] RESET_LAST = 8'(RESET_PULSES - 1);

  logic [1:0]  op_q, op_d;
  logic [7:0]  phase_q, phase_d;
  logic        half_q, half_d;
  logic [7:0]  tick_q, tick_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  addr_q, addr_d;
  logic [31:0] data_q, data_d;
  logic [5:0]  status_q, status_d;

  logic [7:0]  last_slot;
  logic [7:0]  tick_inc;
  logic [1:0]  recv;
  logic        wr;
  logic        clk_lvl, dat_lvl, drv, busy, done;

  // one tick of the wire sequencer
  always_comb begin
    op_d     = op_q;
    phase_d  = phase_q;
    half_d   = half_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    addr_d   = addr_q;
    data_d   = data_q;
    status_d = status_q;
    last_slot = LAST_SLOT_RW;
    tick_inc = 8'd0;
    recv     = RECV_NONE;
    wr       = 1'b0;
    clk_lvl  = 1'b1;
    dat_lvl  = 1'b1;
    drv      = 1'b1;
    busy     = 1'b0;
    done     = 1'b0;

    // frame start from idle
    if (op_q == OP_IDLE && item_i.command != OP_IDLE) begin
      op_d     = item_i.command;
      phase_d  = 8'd0;
      half_d   = 1'b0;
      tick_d   = 8'd0;
      status_d = 6'd0;
      if (item_i.command == OP_WRITE) begin
        addr_d  = {item_i.address, 1'b1};
        shift_d = item_i.write_data;
      end else if (item_i.command == OP_READ) begin
        addr_d  = {item_i.address, 1'b0};
        shift_d = 32'd0;
      end
    end

    if (op_d != OP_IDLE) begin
      busy    = 1'b1;
      wr      = (op_d == OP_WRITE);
      clk_lvl = half_d;
      if (op_d == OP_LRESET) begin
        last_slot = RESET_LAST;
        dat_lvl   = 1'b1;
      end else if (phase_d == 8'd0) begin
        // start condition
        clk_lvl = 1'b1;
        dat_lvl = 1'b0;
      end else if (phase_d <= 8'd8) begin
        dat_lvl = addr_d[3'(8'd8 - phase_d)];
      end else if (phase_d <= 8'd10) begin
        dat_lvl = ^addr_d;
      end else if (phase_d < (wr ? 8'd15 : 8'd14)) begin
        dat_lvl = 1'b0;
      end else if (phase_d <= 8'd52) begin
        if (wr && phase_d <= 8'd46) begin
          dat_lvl = shift_d[5'(8'd46 - phase_d)];
        end else if (wr && phase_d <= 8'd48) begin
          dat_lvl = ^shift_d;
        end else begin
          // line released for the target
          drv     = 1'b0;
          dat_lvl = 1'b0;
          if (wr) begin
            recv = RECV_STAT;
          end else if (phase_d == 8'd14) begin
            recv = RECV_NONE;
          end else if (phase_d <= 8'd46) begin
            recv = RECV_DATA;
          end else begin
            recv = RECV_STAT;
          end
        end
      end else if (phase_d == 8'd53) begin
        dat_lvl = 1'b0;
      end else begin
        // stop condition
        clk_lvl = 1'b1;
        dat_lvl = 1'b1;
      end

      // sample on the first tick of a clock-high half
      if (recv != RECV_NONE && half_d && tick_d == 8'd0) begin
        if (recv == RECV_DATA) begin
          shift_d = {shift_d[30:0], item_i.data_pin_in};
          if (phase_d == 8'd46) begin
            data_d = shift_d;
          end
        end else begin
          status_d = {status_d[4:0], item_i.data_pin_in};
        end
      end

      // half-period timing and slot advance
      tick_inc = tick_d + 8'd1;
      if (tick_inc >= half_period_i || tick_inc == 8'd0) begin
        tick_d = 8'd0;
        if (!half_d) begin
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (phase_d >= last_slot) begin
            done    = 1'b1;
            op_d    = OP_IDLE;
            phase_d = 8'd0;
          end else begin
            phase_d = phase_d + 8'd1;
          end
        end
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_IDLE;
      phase_q  <= 8'd0;
      half_q   <= 1'b0;
      tick_q   <= 8'd0;
      shift_q  <= 32'd0;
      addr_q   <= 8'd0;
      data_q   <= 32'd0;
      status_q <= 6'd0;
    end else if (step_i) begin
      op_q     <= op_d;
      phase_q  <= phase_d;
      half_q   <= half_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      addr_q   <= addr_d;
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  // result of this tick
  always_comb begin
    res_o.clock_level  = clk_lvl;
    res_o.data_level   = dat_lvl;
    res_o.data_drive   = drv;
    res_o.busy_res     = busy;
    res_o.done_res     = done;
    res_o.read_data    = data_d;
    res_o.reply_status = status_d[3:0];
    res_o.reply_parity = status_d[5:4];
  end

endmodule

// ===== rtl/two_wire_debug_dmi_master_unit.sv =====
// two-wire debug bus dmi master, top level
// path from input transaction to result: input register, frame sequencer, result register
// throughput: one tick per cycle while the result side does not stall; the handshake in this unit sets it
// reset: asynchronous active low; line idle, half period 1, captured data cleared
// depends on tw_dmi_pkg and tw_dmi_frame
module two_wire_debug_dmi_master_unit #(
  parameter int RESET_PULSES = tw_dmi_pkg::RESET_PULSES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tw_dmi_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tw_dmi_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);
  import tw_dmi_pkg::*;

  logic       in_valid_q, in_valid_d;
  in_item_t   in_item_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q;
  out_item_t  res;
  logic [7:0] half_period_q;
  logic       advance;
  logic       in_accept;

  // pipeline handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      half_period_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  // frame sequencer
  tw_dmi_frame #(
    .RESET_PULSES(RESET_PULSES)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .half_period_i(half_period_q),
    .res_o        (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  // checks
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> out_item_o.busy_res)
    else $error("done without busy");

  a_idle_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |->
      out_item_o.clock_level && out_item_o.data_level && out_item_o.data_drive)
    else $error("idle line not high and driven");

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.data_drive |-> !out_item_o.data_level)
    else $error("released data level not zero");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled input transaction lost");

endmodule

// ===== tb/tw_dmi_wire_checker.sv =====
// checker for the two-wire debug bus dmi master: watches the input, result and
// configuration channels, predicts every wire tick and compares the results
// depends on tw_dmi_pkg
module tw_dmi_wire_checker #(
  parameter int RESET_PULSES = tw_dmi_pkg::RESET_PULSES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  tw_dmi_pkg::in_item_t  in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  tw_dmi_pkg::out_item_t out_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [7:0]            cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tw_dmi_pkg::*;

  // what a receive slot captures
  typedef enum logic [1:0] {RX_NONE, RX_DATA, RX_STATUS} rx_kind_e;

  localparam logic [7:0] LRESET_LAST = (RESET_PULSES < 1) ? 8'd0 : 8'(RESET_PULSES - 1);
  localparam int MAX_PRINTED = 40;

  // predicted sequencer state
  logic [7:0]  half_period;
  logic [1:0]  cur_op;
  logic [7:0]  slot;
  logic        half;
  logic [7:0]  tick_cnt;
  logic [31:0] shreg;
  logic [7:0]  addr_byte;
  logic [31:0] cap_data;
  logic [5:0]  cap_status;

  out_item_t wire_levels_q[$];
  out_item_t want;
  int        mismatch_count;
  int        result_idx;

  // one tick of the frame sequencer, returns the pin levels and captured values
  function automatic out_item_t advance_wire(in_item_t it);
    out_item_t r;
    logic      clk_l, dat_l, drv_l, busy_l, done_l, wr;
    logic [7:0] s, last_slot;
    logic      h;
    rx_kind_e  recv;
    clk_l  = 1'b1;
    dat_l  = 1'b1;
    drv_l  = 1'b1;
    busy_l = 1'b0;
    done_l = 1'b0;
    recv   = RX_NONE;
    last_slot = LAST_SLOT_RW;

    // a command on an idle line starts its frame on this tick
    if (cur_op == OP_IDLE && it.command != OP_IDLE) begin
      cur_op     = it.command;
      slot       = '0;
      half       = 1'b0;
      tick_cnt   = '0;
      cap_status = '0;
      if (it.command == OP_WRITE) begin
        addr_byte = {it.address, 1'b1};
        shreg     = it.write_data;
      end else if (it.command == OP_READ) begin
        addr_byte = {it.address, 1'b0};
        shreg     = '0;
      end
    end

    if (cur_op != OP_IDLE) begin
      s      = slot;
      h      = half;
      wr     = (cur_op == OP_WRITE);
      busy_l = 1'b1;
      if (cur_op == OP_LRESET) begin
        last_slot = LRESET_LAST;
        clk_l     = h;
        dat_l     = 1'b1;
      end else begin
        clk_l = h;
        if (s == 8'd0) begin
          // start: data low under a high clock
          clk_l = 1'b1;
          dat_l = 1'b0;
        end else if (s <= 8'd8) begin
          dat_l = addr_byte[3'(8'd8 - s)];
        end else if (s <= 8'd10) begin
          dat_l = ^addr_byte;
        end else if (s < (wr ? 8'd15 : 8'd14)) begin
          dat_l = 1'b0;
        end else if (s <= 8'd52) begin
          if (wr && s <= 8'd46) begin
            dat_l = shreg[5'(8'd46 - s)];
          end else if (wr && s <= 8'd48) begin
            dat_l = ^shreg;
          end else begin
            // line released for the target
            drv_l = 1'b0;
            dat_l = 1'b0;
            if (wr) recv = RX_STATUS;
            else if (s == 8'd14) recv = RX_NONE;
            else recv = (s <= 8'd46) ? RX_DATA : RX_STATUS;
          end
        end else if (s == 8'd53) begin
          dat_l = 1'b0;
        end else begin
          clk_l = 1'b1;
          dat_l = 1'b1;
        end
      end

      // sample on the first tick of a clock-high half
      if (recv != RX_NONE && h && tick_cnt == 8'd0) begin
        if (recv == RX_DATA) begin
          shreg = {shreg[30:0], it.data_pin_in};
          if (s == 8'd46) cap_data = shreg;
        end else begin
          cap_status = {cap_status[4:0], it.data_pin_in};
        end
      end

      // half-period count, a zero period acts as one
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= half_period || tick_cnt == 8'd0) begin
        tick_cnt = '0;
        if (!h) begin
          half = 1'b1;
        end else begin
          half = 1'b0;
          if (s >= last_slot) begin
            done_l = 1'b1;
            cur_op = OP_IDLE;
            slot   = '0;
          end else begin
            slot = s + 8'd1;
          end
        end
      end
    end

    r.clock_level  = clk_l;
    r.data_level   = dat_l;
    r.data_drive   = drv_l;
    r.busy_res     = busy_l;
    r.done_res     = done_l;
    r.read_data    = cap_data;
    r.reply_status = cap_status[3:0];
    r.reply_parity = cap_status[5:4];
    return r;
  endfunction

  // print one line per mismatch, up to a cap, and count all of them
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: result %0d: %s got %h expected %h", $realtime, result_idx, what,
               got, exp_val);
    mismatch_count++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t exp_val);
    if (got.clock_level !== exp_val.clock_level)
      report_mismatch("clock_level", 32'(got.clock_level), 32'(exp_val.clock_level));
    if (got.data_level !== exp_val.data_level)
      report_mismatch("data_level", 32'(got.data_level), 32'(exp_val.data_level));
    if (got.data_drive !== exp_val.data_drive)
      report_mismatch("data_drive", 32'(got.data_drive), 32'(exp_val.data_drive));
    if (got.busy_res !== exp_val.busy_res)
      report_mismatch("busy_res", 32'(got.busy_res), 32'(exp_val.busy_res));
    if (got.done_res !== exp_val.done_res)
      report_mismatch("done_res", 32'(got.done_res), 32'(exp_val.done_res));
    if (got.read_data !== exp_val.read_data)
      report_mismatch("read_data", got.read_data, exp_val.read_data);
    if (got.reply_status !== exp_val.reply_status)
      report_mismatch("reply_status", 32'(got.reply_status), 32'(exp_val.reply_status));
    if (got.reply_parity !== exp_val.reply_parity)
      report_mismatch("reply_parity", 32'(got.reply_parity), 32'(exp_val.reply_parity));
  endtask

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period    = HALF_PERIOD_RESET;
      cur_op         = OP_IDLE;
      slot           = '0;
      half           = 1'b0;
      tick_cnt       = '0;
      shreg          = '0;
      addr_byte      = '0;
      cap_data       = '0;
      cap_status     = '0;
      mismatch_count = 0;
      result_idx     = 0;
      wire_levels_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // configuration transaction
      if (cfg_valid_i && cfg_ready_i) half_period = cfg_data_i;

      // result transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (wire_levels_q.size() == 0) begin
          report_mismatch("result with none expected, read_data", out_item_i.read_data, '0);
        end else begin
          want = wire_levels_q.pop_front();
          compare_result(out_item_i, want);
        end
        result_idx++;
      end

      // input transaction
      if (in_valid_i && !in_stall_i) wire_levels_q.push_back(advance_wire(in_item_i));

      pending_o <= wire_levels_q.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

// ===== tb/tb_two_wire_debug_dmi_master_unit.sv =====
// testbench top for the two-wire debug bus dmi master: drives ticks and half
// periods with random gaps and stalls and gives the verdict
// depends on tw_dmi_pkg, two_wire_debug_dmi_master_unit and tw_dmi_wire_checker
module tb_two_wire_debug_dmi_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tw_dmi_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  int pending;
  int errors;
  int idle_cycles;
  bit quiet_tx;
  bit quiet_rx;

  two_wire_debug_dmi_master_unit #(
    .RESET_PULSES (RESET_PULSES_DEFAULT)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  tw_dmi_wire_checker #(
    .RESET_PULSES (RESET_PULSES_DEFAULT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic in_item_t make_tick(logic [1:0] cmd, logic [6:0] addr,
                                         logic [31:0] data, logic pin);
    in_item_t it;
    it.command     = cmd;
    it.address     = addr;
    it.write_data  = data;
    it.data_pin_in = pin;
    return it;
  endfunction

  // mostly plain ticks, now and then a frame command with random content
  function automatic in_item_t random_tick();
    logic [1:0]  cmd;
    logic [6:0]  addr;
    logic [31:0] data;
    cmd  = ($urandom_range(0, 99) < 88) ? OP_IDLE : 2'($urandom_range(1, 3));
    addr = 7'($urandom);
    data = $urandom;
    case ($urandom_range(0, 9))
      0: addr = '0;
      1: addr = '1;
      2: data = '0;
      3: data = '1;
      default: ;
    endcase
    return make_tick(cmd, addr, data, 1'($urandom));
  endfunction

  // one input transaction, valid only dropped for a gap before it
  task automatic send_tick(in_item_t it);
    int gap;
    if (quiet_tx || $urandom_range(0, 2) == 0) gap = 0;
    else gap = $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // result side stalls a random number of cycles after each transaction
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int n;
    int stall_left;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (quiet_rx || $urandom_range(0, 2) == 0) n = 0;
      else n = $urandom_range(0, 19);
      stall_left = n;
      out_stall <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0] phase_hp [NUM_PHASES];
    int         phase_len [NUM_PHASES];
    quiet_tx    = 1'b0;
    quiet_rx    = 1'b0;
    phase_hp  = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd1, 8'd3, 8'd1};
    phase_len = '{200, 80, 150, 60, 200, 80, 80};
    phase_hp[5] = 8'($urandom_range(3, 6));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle line, a write with all-ones fields, commands while busy
    send_tick(make_tick(OP_IDLE, '0, '0, 1'b0));
    send_tick(make_tick(OP_IDLE, '1, '1, 1'b1));
    send_tick(make_tick(OP_WRITE, '1, '1, 1'b1));
    send_tick(make_tick(OP_READ, '0, '0, 1'b0));
    send_tick(make_tick(OP_LRESET, '0, '0, 1'b1));
    send_tick(make_tick(OP_WRITE, '0, '0, 1'b0));
    for (int i = 0; i < 12; i++)
      send_tick(make_tick(OP_IDLE, 7'($urandom), $urandom, 1'(i)));

    // random phases, period changes land mid-frame too
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_half_period(phase_hp[p]);
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len[p]; i++)
        send_tick(random_tick());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
